### src/ilt_pkg.sv
// Shared types and constants of the IP lease table.
`timescale 1ns / 1ps

package ilt_pkg;

	localparam int unsigned HW_W  = 48;
	localparam int unsigned IP_W  = 32;
	localparam int unsigned ST_W  = 3;
	localparam int unsigned CFG_W = 32;

	// Command codes
	localparam logic CMD_ALLOCATE = 1'b0;
	localparam logic CMD_RELEASE  = 1'b1;

	// Status codes
	localparam logic [ST_W-1:0] STATUS_EXISTING  = 3'd0;
	localparam logic [ST_W-1:0] STATUS_NEW       = 3'd1;
	localparam logic [ST_W-1:0] STATUS_FULL      = 3'd2;
	localparam logic [ST_W-1:0] STATUS_RELEASED  = 3'd3;
	localparam logic [ST_W-1:0] STATUS_NOT_FOUND = 3'd4;

	// Configuration register indexes
	localparam logic REG_POOL_FIRST = 1'b0;
	localparam logic REG_POOL_LAST  = 1'b1;

	// Register reset values (192.168.1.100 and 192.168.1.200)
	localparam logic [IP_W-1:0] POOL_FIRST_RST = 32'hC0A8_0164;
	localparam logic [IP_W-1:0] POOL_LAST_RST  = 32'hC0A8_01C8;

	typedef struct packed {
		logic            command;
		logic [HW_W-1:0] hw_address;
		logic [IP_W-1:0] release_ip;
	} cmd_t;

	typedef struct packed {
		logic [IP_W-1:0] assigned_ip;
		logic [ST_W-1:0] status;
	} rsp_t;

	typedef struct packed {
		logic [HW_W-1:0] hw;
		logic [IP_W-1:0] ip;
	} entry_t;

endpackage

### src/ilt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ilt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                                           clk,
	input  logic                                           we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
	input  logic [WIDTH-1:0]                               wdata,
	input  logic                                           re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
	output logic [WIDTH-1:0]                               rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### src/ilt_match.sv
// Shared key compare: hardware address for allocate, IPv4 address for release.
`timescale 1ns / 1ps

module ilt_match
	import ilt_pkg::*;
(
	input  logic   command,
	input  cmd_t   item,
	input  entry_t entry,
	output logic   hit
);

	always_comb begin
		case (command)
			CMD_ALLOCATE: hit = (entry.hw == item.hw_address);
			CMD_RELEASE:  hit = (entry.ip == item.release_ip);
			default:      hit = 1'b0;
		endcase
	end

endmodule

### src/ip_lease_table.sv
// Top level of the IP lease table: scan sequencer, lease store and registers.
`timescale 1ns / 1ps

// Channel   Ports                          Beat taken when
// --------  -----------------------------  ---------------------------------
// command   start, busy, cmd (cmd_t)       start high and busy low at clk
// result    done, rsp (rsp_t)              done high (one cycle, no stall)
// config    cfg_we, cfg_index, cfg_wdata   cfg_we high at clk
//
// Operation: a command scans the valid entries through the RAM read port,
// one per cycle, the compare acting on the registered read data in the
// cycle after the read, and stops at the first hit. A release hit then
// reads the last entry and moves it into the hole. busy is high for the
// whole command.
// Reset: count cleared, pool registers and next-address pointer to their
// defaults; the lease store is not cleared, as only entries below the count
// are ever read. The receiver cannot stall: done is a one-cycle strobe.

module ip_lease_table
	import ilt_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  cmd_t             cmd,
	output logic             done,
	output rsp_t             rsp,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	// One-hot sequencer states
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_LAST = 4'b0100,
		S_MOVE = 4'b1000
	} state_t;

	state_t          state_q;
	cmd_t            cmd_q;
	logic [CW-1:0]   count_q;
	logic [IP_W-1:0] next_q;
	logic [IP_W-1:0] pool_first_q;
	logic [IP_W-1:0] pool_last_q;
	logic [CW-1:0]   idx_q;
	logic            pend_s1;
	logic [AW-1:0]   pend_idx_s1;
	logic [AW-1:0]   hit_idx_q;
	logic            done_q;
	rsp_t            rsp_q;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	entry_t          ram_wdata;
	logic            ram_re;
	logic [AW-1:0]   ram_raddr;
	entry_t          ram_rdata;
	logic            hit;
	logic            issue;
	logic            cmp_hit;
	logic            scan_end;
	logic            room;
	logic [CW-1:0]   last_idx;

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	assign issue    = (idx_q < count_q);
	assign cmp_hit  = pend_s1 && hit;
	assign scan_end = !issue && !pend_s1;
	assign room     = (count_q < CW'(TABLE_DEPTH)) && (next_q <= pool_last_q);
	assign last_idx = count_q - CW'(1);

	ilt_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ilt_match u_match (
		.command (cmd_q.command),
		.item    (cmd_q),
		.entry   (ram_rdata),
		.hit     (hit)
	);

	// Read port: walk the table while scanning, fetch the last entry on release
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = idx_q[AW-1:0];
		case (state_q)
			S_SCAN: begin
				ram_re = issue && !cmp_hit;
			end
			S_LAST: begin
				ram_re    = 1'b1;
				ram_raddr = last_idx[AW-1:0];
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	// Write port: append on an allocate miss with room, move last entry into the hole
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = '{hw: cmd_q.hw_address, ip: next_q};
		case (state_q)
			S_SCAN: begin
				ram_we = scan_end && !cmp_hit && (cmd_q.command == CMD_ALLOCATE) && room;
			end
			S_MOVE: begin
				ram_we    = 1'b1;
				ram_waddr = hit_idx_q;
				ram_wdata = ram_rdata;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			next_q       <= POOL_FIRST_RST;
			pool_first_q <= POOL_FIRST_RST;
			pool_last_q  <= POOL_LAST_RST;
			idx_q        <= '0;
			pend_s1      <= 1'b0;
			pend_idx_s1  <= '0;
			hit_idx_q    <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;

			// The user must send configuration beats only while idle; the block has no check for it
			if (cfg_we) begin
				case (cfg_index)
					REG_POOL_FIRST: begin
						pool_first_q <= cfg_wdata;
						next_q       <= cfg_wdata;
					end
					REG_POOL_LAST: begin
						pool_last_q <= cfg_wdata;
					end
					default: begin
						pool_last_q <= pool_last_q;
					end
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (start) begin
						idx_q   <= '0;
						pend_s1 <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (cmp_hit) begin
						pend_s1 <= 1'b0;
						if (cmd_q.command == CMD_ALLOCATE) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							hit_idx_q <= pend_idx_s1;
							state_q   <= S_LAST;
						end
					end else if (scan_end) begin
						// Miss: an allocate appends when there is room; otherwise only report
						done_q  <= 1'b1;
						state_q <= S_IDLE;
						if ((cmd_q.command == CMD_ALLOCATE) && room) begin
							count_q <= count_q + CW'(1);
							next_q  <= next_q + IP_W'(1);
						end
					end else begin
						// Advance the read pointer and track the beat in flight
						idx_q       <= idx_q + CW'(issue);
						pend_s1     <= issue;
						pend_idx_s1 <= idx_q[AW-1:0];
					end
				end
				S_LAST: begin
					state_q <= S_MOVE;
				end
				S_MOVE: begin
					count_q <= last_idx;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Command register loaded on accept; result register loaded in the cycle that finishes a command
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && start && !busy) begin
			cmd_q <= cmd;
		end
		case (state_q)
			S_SCAN: begin
				if (cmp_hit) begin
					rsp_q <= '{assigned_ip: ram_rdata.ip, status: STATUS_EXISTING};
				end else if (scan_end) begin
					if (cmd_q.command == CMD_RELEASE) begin
						rsp_q <= '{assigned_ip: '0, status: STATUS_NOT_FOUND};
					end else if (room) begin
						rsp_q <= '{assigned_ip: next_q, status: STATUS_NEW};
					end else begin
						rsp_q <= '{assigned_ip: '0, status: STATUS_FULL};
					end
				end
			end
			S_MOVE: begin
				rsp_q <= '{assigned_ip: '0, status: STATUS_RELEASED};
			end
			default: begin
				rsp_q <= rsp_q;
			end
		endcase
	end

endmodule
